### src/sdth_pkg.sv
package sdth_pkg;

    localparam int POS_W         = 12;
    localparam int LEN_W         = 24;
    localparam int CNT_W         = 16;
    localparam int SPU_W         = 11;
    localparam int BIN_COUNT_DEF = 1024;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // sector edges, 2048-count arena and 1800-count arena
    localparam logic signed [POS_W-1:0] EDGE_IN_A  = 12'sd512;
    localparam logic signed [POS_W-1:0] EDGE_OUT_A = 12'sd1536;
    localparam logic signed [POS_W-1:0] EDGE_IN_B  = 12'sd450;
    localparam logic signed [POS_W-1:0] EDGE_OUT_B = 12'sd1350;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ARENA  = 2'd0;
    localparam logic [1:0] REG_HEATED = 2'd1;
    localparam logic [1:0] REG_SPU    = 2'd2;

    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic             arena_type;
        logic             heated_pattern;
        logic [SPU_W-1:0] samples_per_unit;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic hot;
    } hist_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } hist_resp_t;

endpackage

### src/sdth_cfg.sv
module sdth_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sdth_pkg::ADDR_W-1:0]  paddr,
    input  logic [sdth_pkg::DATA_W-1:0]  pwdata,
    output logic [sdth_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output sdth_pkg::cfg_t               cfg
);

    sdth_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arena_type       <= 1'b0;
            cfg_reg.heated_pattern   <= 1'b0;
            cfg_reg.samples_per_unit <= sdth_pkg::SPU_W'(1);
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                sdth_pkg::REG_ARENA:  cfg_reg.arena_type <= pwdata[0];
                sdth_pkg::REG_HEATED: cfg_reg.heated_pattern <= pwdata[0];
                sdth_pkg::REG_SPU:
                    cfg_reg.samples_per_unit <= pwdata[sdth_pkg::SPU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sdth_pkg::REG_ARENA:
                prdata = sdth_pkg::DATA_W'(cfg_reg.arena_type);
            sdth_pkg::REG_HEATED:
                prdata = sdth_pkg::DATA_W'(cfg_reg.heated_pattern);
            sdth_pkg::REG_SPU:
                prdata = sdth_pkg::DATA_W'(cfg_reg.samples_per_unit);
            default:
                prdata = '0;
        endcase
    end

endmodule

### src/sdth_div.sv
module sdth_div #(
    parameter int DW = sdth_pkg::LEN_W,
    parameter int VW = sdth_pkg::SPU_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign fits     = trial >= {1'b0, div_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                div_reg  <= divisor;
                cnt_reg  <= CW'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[VW-1:0] : trial[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### src/sdth_hist.sv
module sdth_hist #(
    parameter int BIN_COUNT = sdth_pkg::BIN_COUNT_DEF,
    localparam int BIN_W = $clog2(BIN_COUNT)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdth_pkg::hist_req_t    req,
    input  logic [BIN_W-1:0]       bin,
    input  logic                   clear,
    output logic                   busy,
    output sdth_pkg::hist_resp_t   resp
);

    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_COUNT - 1);

    logic [sdth_pkg::CNT_W-1:0] hot_mem  [BIN_COUNT];
    logic [sdth_pkg::CNT_W-1:0] cold_mem [BIN_COUNT];

    logic [sdth_pkg::CNT_W-1:0] hot_rd_reg;
    logic [sdth_pkg::CNT_W-1:0] cold_rd_reg;
    logic [BIN_W-1:0]           addr_reg;
    logic                       hot_sel_reg;
    logic                       pend_reg;
    logic                       clr_busy_reg;
    logic [BIN_W-1:0]           clr_addr_reg;
    logic [sdth_pkg::CNT_W-1:0] old_cnt;
    logic [sdth_pkg::CNT_W-1:0] new_cnt;

    assign old_cnt = hot_sel_reg ? hot_rd_reg : cold_rd_reg;
    assign new_cnt = (old_cnt == sdth_pkg::CNT_MAX) ? old_cnt
                                                    : old_cnt + sdth_pkg::CNT_W'(1);
    assign resp.done  = pend_reg;
    assign resp.count = new_cnt;
    assign busy       = clr_busy_reg;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            hot_mem[clr_addr_reg]  <= '0;
            cold_mem[clr_addr_reg] <= '0;
        end
        else if (pend_reg)
        begin
            if (hot_sel_reg)
                hot_mem[addr_reg] <= new_cnt;
            else
                cold_mem[addr_reg] <= new_cnt;
        end
        if (req.valid)
        begin
            hot_rd_reg  <= hot_mem[bin];
            cold_rd_reg <= cold_mem[bin];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            hot_sel_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            pend_reg <= req.valid;
            if (req.valid)
            begin
                addr_reg    <= bin;
                hot_sel_reg <= req.hot;
            end
            if (clear)
            begin
                clr_busy_reg <= 1'b1;
                clr_addr_reg <= '0;
            end
            else if (clr_busy_reg)
            begin
                if (clr_addr_reg == BIN_LAST)
                    clr_busy_reg <= 1'b0;
                else
                    clr_addr_reg <= clr_addr_reg + BIN_W'(1);
            end
        end
    end

endmodule

### src/sector_dwell_time_histogram_top.sv
// Sector dwell-time histogram. Position samples are classified into four
// sectors; runs of equal sector are closed on a sector change or at the
// block end, and each closed run bumps one bin ((L-1) / samples_per_unit,
// capped at BIN_COUNT-1) of the hot or cold histogram held in block RAM.
// A sample that closes no run is only accepted. One that closes a run passes
// the accept, a divider load state, 24 steps of the bit-serial 24-bit
// divider and one to take its quotient, the RAM read, the read-modify-write
// and the result hand-off, which waits for a free output; a last sample
// that also changes sector closes two runs in turn. The last sample of a
// block also emits a summary transfer and then sweeps both histograms to
// zero, one bin per cycle; the same sweep runs after reset. Input is not
// taken during the sweep; configuration writes are.
module sector_dwell_time_histogram_top #(
    parameter int BIN_COUNT = sdth_pkg::BIN_COUNT_DEF,
    localparam int BIN_W = $clog2(BIN_COUNT),
    localparam int OUT_RAW = 1 + BIN_W + sdth_pkg::CNT_W + 2 * sdth_pkg::LEN_W
                             + 2 * sdth_pkg::CNT_W,
    localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // position [11:0]
    input  logic [15:0]                  s_axis_tdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic                         s_axis_tlast,
    // is_hot, bin_index, bin_count, hot_dwell_sum, cold_dwell_sum,
    // hot_runs, cold_runs
    output logic [OUT_W-1:0]             m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic                         m_axis_tlast,
    // kind
    output logic                         m_axis_tuser,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sdth_pkg::ADDR_W-1:0]  paddr,
    input  logic [sdth_pkg::DATA_W-1:0]  pwdata,
    output logic [sdth_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int LEN_W = sdth_pkg::LEN_W;
    localparam int CNT_W = sdth_pkg::CNT_W;
    localparam int SPU_W = sdth_pkg::SPU_W;
    localparam logic [LEN_W-1:0] BIN_MAX = LEN_W'(BIN_COUNT - 1);

    localparam logic [1:0] SEC_CENTER = 2'd0;
    localparam logic [1:0] SEC_RIGHT  = 2'd1;
    localparam logic [1:0] SEC_OUTER  = 2'd2;
    localparam logic [1:0] SEC_LEFT   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DSTART,
        ST_DIV,
        ST_HREQ,
        ST_HWAIT,
        ST_OUT,
        ST_SUM
    } state_t;

    sdth_pkg::cfg_t       cfg;
    sdth_pkg::hist_req_t  hreq;
    sdth_pkg::hist_resp_t hresp;
    logic                 hist_busy;
    logic                 hist_clear;

    state_t               state_reg;
    logic [1:0]           prev_sec_reg;
    logic [LEN_W-1:0]     run_len_reg;
    logic                 started_reg;
    logic [LEN_W-1:0]     hot_sum_reg;
    logic [LEN_W-1:0]     cold_sum_reg;
    logic [CNT_W-1:0]     hot_runs_reg;
    logic [CNT_W-1:0]     cold_runs_reg;
    logic                 switch_reg;
    logic [1:0]           new_sec_reg;
    logic                 last_reg;
    logic [BIN_W-1:0]     bin_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [OUT_W-1:0]     out_data_reg;
    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic                 out_kind_reg;

    logic signed [11:0]   pos;
    logic signed [11:0]   e_in;
    logic signed [11:0]   e_out;
    logic [1:0]           sec;
    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic                 hot;
    logic [LEN_W-1:0]     len_eff;
    logic [SPU_W-1:0]     divisor;
    logic                 div_start;
    logic                 div_done;
    logic [LEN_W-1:0]     quo;
    logic [LEN_W:0]       hot_sum_add;
    logic [LEN_W:0]       cold_sum_add;
    logic [LEN_W:0]       len_add;

    sdth_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdth_div #(
        .DW (LEN_W),
        .VW (SPU_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (len_eff - LEN_W'(1)),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quo)
    );

    sdth_hist #(
        .BIN_COUNT (BIN_COUNT)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .bin   (bin_reg),
        .clear (hist_clear),
        .busy  (hist_busy),
        .resp  (hresp)
    );

    assign pos   = signed'(s_axis_tdata[11:0]);
    assign e_in  = cfg.arena_type ? sdth_pkg::EDGE_IN_B  : sdth_pkg::EDGE_IN_A;
    assign e_out = cfg.arena_type ? sdth_pkg::EDGE_OUT_B : sdth_pkg::EDGE_OUT_A;

    always_comb
    begin
        if (pos >= -e_out && pos < -e_in)
            sec = SEC_LEFT;
        else if (pos >= -e_in && pos < e_in)
            sec = SEC_CENTER;
        else if (pos >= e_in && pos < e_out)
            sec = SEC_RIGHT;
        else
            sec = SEC_OUTER;
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !hist_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = ((state_reg == ST_OUT) || (state_reg == ST_SUM)) && out_free;
    assign hot           = prev_sec_reg[0] == cfg.heated_pattern;
    assign len_eff       = (run_len_reg == '0) ? LEN_W'(1) : run_len_reg;
    assign divisor       = (cfg.samples_per_unit == '0) ? SPU_W'(1)
                                                        : cfg.samples_per_unit;
    assign div_start     = state_reg == ST_DSTART;
    assign hreq.valid    = state_reg == ST_HREQ;
    assign hreq.hot      = hot;
    assign hist_clear    = (state_reg == ST_SUM) && out_free;

    assign hot_sum_add  = {1'b0, hot_sum_reg} + {1'b0, len_eff};
    assign cold_sum_add = {1'b0, cold_sum_reg} + {1'b0, len_eff};
    assign len_add      = {1'b0, run_len_reg} + (LEN_W + 1)'(1);

    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_sec_reg  <= SEC_CENTER;
            run_len_reg   <= '0;
            started_reg   <= 1'b0;
            hot_sum_reg   <= '0;
            cold_sum_reg  <= '0;
            hot_runs_reg  <= '0;
            cold_runs_reg <= '0;
            switch_reg    <= 1'b0;
            new_sec_reg   <= SEC_CENTER;
            last_reg      <= 1'b0;
            bin_reg       <= '0;
            cnt_reg       <= '0;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_kind_reg  <= sdth_pkg::KIND_RUN;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= s_axis_tlast;
                        if (!started_reg)
                        begin
                            started_reg  <= 1'b1;
                            prev_sec_reg <= sec;
                            run_len_reg  <= LEN_W'(1);
                            switch_reg   <= 1'b0;
                            if (s_axis_tlast)
                                state_reg <= ST_DSTART;
                        end
                        else if (sec == prev_sec_reg)
                        begin
                            run_len_reg <= len_add[LEN_W] ? sdth_pkg::LEN_MAX
                                                          : len_add[LEN_W-1:0];
                            switch_reg  <= 1'b0;
                            if (s_axis_tlast)
                                state_reg <= ST_DSTART;
                        end
                        else
                        begin
                            switch_reg  <= 1'b1;
                            new_sec_reg <= sec;
                            state_reg   <= ST_DSTART;
                        end
                    end
                end

                ST_DSTART:
                    state_reg <= ST_DIV;

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        bin_reg   <= (quo > BIN_MAX) ? BIN_MAX[BIN_W-1:0]
                                                     : quo[BIN_W-1:0];
                        state_reg <= ST_HREQ;
                    end
                end

                ST_HREQ:
                    state_reg <= ST_HWAIT;

                ST_HWAIT:
                begin
                    if (hresp.done)
                    begin
                        cnt_reg   <= hresp.count;
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= sdth_pkg::KIND_RUN;
                        out_last_reg  <= !last_reg;
                        out_data_reg  <= OUT_W'({cnt_reg, bin_reg, hot});
                        if (hot)
                        begin
                            hot_sum_reg <= hot_sum_add[LEN_W] ? sdth_pkg::LEN_MAX
                                                              : hot_sum_add[LEN_W-1:0];
                            if (hot_runs_reg != sdth_pkg::CNT_MAX)
                                hot_runs_reg <= hot_runs_reg + CNT_W'(1);
                        end
                        else
                        begin
                            cold_sum_reg <= cold_sum_add[LEN_W] ? sdth_pkg::LEN_MAX
                                                                : cold_sum_add[LEN_W-1:0];
                            if (cold_runs_reg != sdth_pkg::CNT_MAX)
                                cold_runs_reg <= cold_runs_reg + CNT_W'(1);
                        end
                        if (switch_reg)
                        begin
                            switch_reg   <= 1'b0;
                            prev_sec_reg <= new_sec_reg;
                            run_len_reg  <= LEN_W'(1);
                            state_reg    <= last_reg ? ST_DSTART : ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SUM;
                        end
                    end
                end

                ST_SUM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= sdth_pkg::KIND_SUMMARY;
                        out_last_reg  <= 1'b1;
                        out_data_reg  <= OUT_W'({cold_runs_reg, hot_runs_reg,
                                                 cold_sum_reg, hot_sum_reg,
                                                 {(CNT_W + BIN_W + 1){1'b0}}});
                        prev_sec_reg  <= SEC_CENTER;
                        run_len_reg   <= '0;
                        started_reg   <= 1'b0;
                        hot_sum_reg   <= '0;
                        cold_sum_reg  <= '0;
                        hot_runs_reg  <= '0;
                        cold_runs_reg <= '0;
                        last_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
